// ===== sv/sbue_pkg.sv =====
// Shared constants, types and helpers for the SGD bias update engine.
// No dependencies; used by sgd_bias_update_engine.
package sbue_pkg;

    localparam int USER_COUNT  = 524288;
    localparam int MOVIE_COUNT = 32768;
    localparam int USER_AW     = $clog2(USER_COUNT);
    localparam int MOVIE_AW    = $clog2(MOVIE_COUNT);
    localparam int CLR_DEPTH   = (USER_COUNT > MOVIE_COUNT) ? USER_COUNT : MOVIE_COUNT;
    localparam int CLR_AW      = $clog2(CLR_DEPTH);

    localparam int BIAS_W = 20;
    localparam int CFG_W  = 19;
    localparam int SQ_W   = 25;

    localparam logic [1:0] CFG_GLOBAL_MEAN   = 2'd0;
    localparam logic [1:0] CFG_LEARNING_RATE = 2'd1;
    localparam logic [1:0] CFG_REG_WEIGHT    = 2'd2;

    localparam logic [18:0] MEAN_RESET = 19'd0;
    localparam logic [15:0] LR_RESET   = 16'd6554;
    localparam logic [15:0] RW_RESET   = 16'd6554;

    localparam logic OP_TRAIN = 1'b0;

    localparam logic signed [27:0] BIAS_MAX = 28'sd524287;
    localparam logic signed [27:0] BIAS_MIN = -28'sd524288;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_READ  = 8'b0000_0100,
        ST_MUL1  = 8'b0000_1000,
        ST_MUL2  = 8'b0001_0000,
        ST_USTEP = 8'b0010_0000,
        ST_MUL3  = 8'b0100_0000,
        ST_MSTEP = 8'b1000_0000
    } state_t;

    function automatic logic signed [19:0] sat_bias(input logic signed [27:0] v);
        logic signed [19:0] r;
        if (v > BIAS_MAX)
            r = 20'sh7FFFF;
        else if (v < BIAS_MIN)
            r = 20'sh80000;
        else
            r = v[19:0];
        return r;
    endfunction

endpackage

// ===== sv/sbue_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sbue_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/sgd_bias_update_engine.sv =====
// Top level of the SGD bias update engine: user and movie bias tables with
// read-modify-write datapath. Depends on sbue_pkg and sbue_ram.
//
//  channel | signals                                              | dir
//  --------+------------------------------------------------------+-----
//  cfg     | cfg_write, cfg_index, cfg_data                       | in
//  in      | in_valid/in_ready, operation, user_index,            | in
//          | movie_index, rating                                  |
//  out     | out_valid/out_ready, user_bias_out, movie_bias_out,  | out
//          | squared_error                                        |
//
// One word at a time: table read, residual, then the user step and the
// dependent movie step, each a multiply chain, then write-back.
// After reset both tables are cleared, one entry per cycle, all 524288 addresses;
// in_ready stays low until then. Config writes are taken at any time.
// The result sits in an output register; the next word is taken while it
// waits, and write-back stalls only when that register is still full.
module sgd_bias_update_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [18:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic [18:0]        user_index,
    input  logic [14:0]        movie_index,
    input  logic [2:0]         rating,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [19:0] user_bias_out,
    output logic signed [19:0] movie_bias_out,
    output logic [24:0]        squared_error
);

    sbue_pkg::state_t state_reg, state_next;

    logic [sbue_pkg::CLR_AW-1:0] clr_cnt_reg;
    logic [31:0]                 clr_ext;
    logic                        clr_done;

    logic [18:0] mean_reg;
    logic [15:0] lr_reg;
    logic [15:0] rw_reg;

    logic [31:0] uidx_ext;
    logic [31:0] midx_ext;
    logic        accept;

    logic                          op_reg;
    logic                          u_ok_reg;
    logic                          m_ok_reg;
    logic [sbue_pkg::USER_AW-1:0]  uaddr_reg;
    logic [sbue_pkg::MOVIE_AW-1:0] maddr_reg;
    logic [2:0]                    rating_reg;

    logic [19:0] u_rdata;
    logic [19:0] m_rdata;

    logic                          u_we;
    logic [sbue_pkg::USER_AW-1:0]  u_waddr;
    logic [19:0]                   u_wdata;
    logic                          m_we;
    logic [sbue_pkg::MOVIE_AW-1:0] m_waddr;
    logic [19:0]                   m_wdata;

    // datapath
    logic signed [19:0] bu_rd, bm_rd;
    logic signed [21:0] e_next;
    logic signed [21:0] e_reg;
    logic signed [19:0] bu_reg, bm_reg;

    logic signed [16:0] lr_s, rw_s;
    logic signed [36:0] pu_prod_next, pm_prod_next;
    logic signed [43:0] sq_prod_next;
    logic signed [36:0] pu_prod_reg, pm_prod_reg;
    logic signed [43:0] sq_prod_reg;

    logic signed [36:0] pu_rnd, pm_rnd;
    logic signed [43:0] sq_rnd;
    logic [27:0]        sq_shr;
    logic signed [24:0] diffu;
    logic signed [41:0] prod_u_next;
    logic signed [41:0] prod_u_reg;
    logic signed [20:0] pen_m_reg;
    logic [24:0]        sq_reg;

    logic signed [41:0] du_rnd;
    logic signed [27:0] bu_sum;
    logic signed [19:0] bu_new_reg;

    logic signed [24:0] diffm;
    logic signed [41:0] prod_m_next;
    logic signed [41:0] prod_m_reg;

    logic signed [41:0] dm_rnd;
    logic signed [27:0] bm_sum;
    logic signed [19:0] bm_new;

    logic go;

    logic               out_valid_reg;
    logic signed [19:0] ub_out_reg;
    logic signed [19:0] mb_out_reg;
    logic [24:0]        sq_out_reg;

    // ---------------- config ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= sbue_pkg::MEAN_RESET;
            lr_reg   <= sbue_pkg::LR_RESET;
            rw_reg   <= sbue_pkg::RW_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sbue_pkg::CFG_GLOBAL_MEAN:   mean_reg <= cfg_data;
                sbue_pkg::CFG_LEARNING_RATE: lr_reg   <= cfg_data[15:0];
                sbue_pkg::CFG_REG_WEIGHT:    rw_reg   <= cfg_data[15:0];
                default:                     ;
            endcase
        end
    end

    // ---------------- control ----------------
    assign clr_ext  = 32'(clr_cnt_reg);
    assign clr_done = (clr_ext == 32'(sbue_pkg::CLR_DEPTH - 1));
    assign in_ready = (state_reg == sbue_pkg::ST_IDLE);
    assign accept   = in_valid & in_ready;
    assign go       = ~out_valid_reg | out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbue_pkg::ST_CLEAR: if (clr_done) state_next = sbue_pkg::ST_IDLE;
            sbue_pkg::ST_IDLE:  if (accept) state_next = sbue_pkg::ST_READ;
            sbue_pkg::ST_READ:  state_next = sbue_pkg::ST_MUL1;
            sbue_pkg::ST_MUL1:  state_next = sbue_pkg::ST_MUL2;
            sbue_pkg::ST_MUL2:  state_next = sbue_pkg::ST_USTEP;
            sbue_pkg::ST_USTEP: state_next = sbue_pkg::ST_MUL3;
            sbue_pkg::ST_MUL3:  state_next = sbue_pkg::ST_MSTEP;
            sbue_pkg::ST_MSTEP: if (go) state_next = sbue_pkg::ST_IDLE;
            default:            state_next = sbue_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sbue_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == sbue_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // ---------------- input capture ----------------
    assign uidx_ext = {13'd0, user_index};
    assign midx_ext = {17'd0, movie_index};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= operation;
            u_ok_reg   <= (uidx_ext < 32'(sbue_pkg::USER_COUNT));
            m_ok_reg   <= (midx_ext < 32'(sbue_pkg::MOVIE_COUNT));
            uaddr_reg  <= uidx_ext[sbue_pkg::USER_AW-1:0];
            maddr_reg  <= midx_ext[sbue_pkg::MOVIE_AW-1:0];
            rating_reg <= rating;
        end
    end

    // ---------------- tables ----------------
    always_comb
    begin
        if (state_reg == sbue_pkg::ST_CLEAR)
        begin
            u_we    = (clr_ext < 32'(sbue_pkg::USER_COUNT));
            u_waddr = clr_ext[sbue_pkg::USER_AW-1:0];
            u_wdata = '0;
            m_we    = (clr_ext < 32'(sbue_pkg::MOVIE_COUNT));
            m_waddr = clr_ext[sbue_pkg::MOVIE_AW-1:0];
            m_wdata = '0;
        end
        else
        begin
            u_we    = (state_reg == sbue_pkg::ST_MSTEP) & go &
                      (op_reg == sbue_pkg::OP_TRAIN) & u_ok_reg;
            u_waddr = uaddr_reg;
            u_wdata = bu_new_reg;
            m_we    = (state_reg == sbue_pkg::ST_MSTEP) & go &
                      (op_reg == sbue_pkg::OP_TRAIN) & m_ok_reg;
            m_waddr = maddr_reg;
            m_wdata = bm_new;
        end
    end

    sbue_ram #(
        .WIDTH(sbue_pkg::BIAS_W),
        .DEPTH(sbue_pkg::USER_COUNT)
    ) u_user_ram (
        .clk  (clk),
        .we   (u_we),
        .waddr(u_waddr),
        .wdata(u_wdata),
        .re   (accept),
        .raddr(uidx_ext[sbue_pkg::USER_AW-1:0]),
        .rdata(u_rdata)
    );

    sbue_ram #(
        .WIDTH(sbue_pkg::BIAS_W),
        .DEPTH(sbue_pkg::MOVIE_COUNT)
    ) u_movie_ram (
        .clk  (clk),
        .we   (m_we),
        .waddr(m_waddr),
        .wdata(m_wdata),
        .re   (accept),
        .raddr(midx_ext[sbue_pkg::MOVIE_AW-1:0]),
        .rdata(m_rdata)
    );

    // ---------------- datapath ----------------
    assign bu_rd  = u_ok_reg ? $signed(u_rdata) : 20'sd0;
    assign bm_rd  = m_ok_reg ? $signed(m_rdata) : 20'sd0;
    assign e_next = $signed({3'b000, rating_reg, 16'h0000}) - $signed({3'b000, mean_reg})
                  - {{2{bu_rd[19]}}, bu_rd} - {{2{bm_rd[19]}}, bm_rd};

    assign lr_s = $signed({1'b0, lr_reg});
    assign rw_s = $signed({1'b0, rw_reg});

    assign pu_prod_next = rw_s * bu_reg;
    assign pm_prod_next = rw_s * bm_reg;
    assign sq_prod_next = e_reg * e_reg;

    // round to nearest, ties up: add half, then arithmetic shift
    assign pu_rnd = pu_prod_reg + 37'sd32768;
    assign pm_rnd = pm_prod_reg + 37'sd32768;
    assign sq_rnd = sq_prod_reg + 44'sd32768;
    assign sq_shr = sq_rnd[43:16];
    assign diffu  = {{3{e_reg[21]}}, e_reg} - {{4{pu_rnd[36]}}, pu_rnd[36:16]};
    assign prod_u_next = lr_s * diffu;

    assign du_rnd = prod_u_reg + 42'sd16384;
    assign bu_sum = {{8{bu_reg[19]}}, bu_reg} + {du_rnd[41], du_rnd[41:15]};

    assign diffm = {{3{e_reg[21]}}, e_reg} + {{5{bu_reg[19]}}, bu_reg}
                 - {{5{bu_new_reg[19]}}, bu_new_reg} - {{4{pen_m_reg[20]}}, pen_m_reg};
    assign prod_m_next = lr_s * diffm;

    assign dm_rnd = prod_m_reg + 42'sd16384;
    assign bm_sum = {{8{bm_reg[19]}}, bm_reg} + {dm_rnd[41], dm_rnd[41:15]};
    assign bm_new = (op_reg == sbue_pkg::OP_TRAIN) ? sbue_pkg::sat_bias(bm_sum) : bm_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            sbue_pkg::ST_READ:
            begin
                e_reg  <= e_next;
                bu_reg <= bu_rd;
                bm_reg <= bm_rd;
            end
            sbue_pkg::ST_MUL1:
            begin
                pu_prod_reg <= pu_prod_next;
                pm_prod_reg <= pm_prod_next;
                sq_prod_reg <= sq_prod_next;
            end
            sbue_pkg::ST_MUL2:
            begin
                prod_u_reg <= prod_u_next;
                pen_m_reg  <= pm_rnd[36:16];
                sq_reg     <= (|sq_shr[27:25]) ? '1 : sq_shr[24:0];
            end
            sbue_pkg::ST_USTEP:
            begin
                bu_new_reg <= (op_reg == sbue_pkg::OP_TRAIN) ?
                              sbue_pkg::sat_bias(bu_sum) : bu_reg;
            end
            sbue_pkg::ST_MUL3:
            begin
                prod_m_reg <= prod_m_next;
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == sbue_pkg::ST_MSTEP) && go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == sbue_pkg::ST_MSTEP) && go)
        begin
            ub_out_reg <= bu_new_reg;
            mb_out_reg <= bm_new;
            sq_out_reg <= sq_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign user_bias_out  = ub_out_reg;
    assign movie_bias_out = mb_out_reg;
    assign squared_error  = sq_out_reg;

endmodule
